// ===== hw/rtl/line_rasterizer_core_macros.svh =====
// Assertion macros for the line rasterizer core.
// Included by files that carry concurrent assertions; no other dependencies.
`ifndef LINE_RASTERIZER_CORE_MACROS_SVH
`define LINE_RASTERIZER_CORE_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define LR_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("line rasterizer assertion failed");

// next-cycle implication, disabled while reset is low
`define LR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("line rasterizer assertion failed");

`endif

// ===== hw/rtl/lr_pkg.sv =====
// Shared types and constants for the line rasterizer core.
// No dependencies; imported by every module of the core.
`timescale 1ns / 1ps

package lr_pkg;

    localparam int COORD_BITS = 12;
    localparam int COLOR_BITS = 16;

    localparam int S_DATA_W = ((4 * COORD_BITS + COLOR_BITS + 7) / 8) * 8;
    localparam int M_DATA_W = ((2 * COORD_BITS + COLOR_BITS + 7) / 8) * 8;

    typedef logic signed [COORD_BITS-1:0] t_coord;
    typedef logic signed [COORD_BITS:0]   t_diff;
    typedef logic        [COORD_BITS-1:0] t_span;
    typedef logic signed [COORD_BITS:0]   t_err;
    typedef logic        [COLOR_BITS-1:0] t_color;

    typedef enum logic {
        CMD_START   = 1'b0,
        CMD_ADVANCE = 1'b1
    } t_cmd;

    // classified command as held in the queue
    typedef struct packed {
        t_cmd   cmd;
        logic   steep;
        logic   minor_dir;   // 1: minor coordinate steps down
        t_coord major_start;
        t_coord minor_start;
        t_coord major_end;
        t_span  major_span;
        t_span  minor_span;
        t_color color;
    } t_lr_entry;

    typedef struct packed {
        logic      valid;
        t_lr_entry entry;
    } t_lr_qout;

    typedef struct packed {
        logic full;
        logic empty;
    } t_lr_qstat;

    typedef struct packed {
        logic pop;
        logic active;
        logic emit_last;
    } t_lr_bstat;

endpackage

// ===== hw/rtl/lr_front.sv =====
// Front end: classifies a command, computing octant, endpoint order and spans.
// Depends on lr_pkg.
`timescale 1ns / 1ps

module lr_front (
    input  lr_pkg::t_cmd      i_cmd,
    input  lr_pkg::t_coord    i_start_x,
    input  lr_pkg::t_coord    i_start_y,
    input  lr_pkg::t_coord    i_end_x,
    input  lr_pkg::t_coord    i_end_y,
    input  lr_pkg::t_color    i_color,
    output lr_pkg::t_lr_entry o_entry
);
    import lr_pkg::*;

    t_diff  w_dx;
    t_diff  w_dy;
    t_diff  w_neg_dx;
    t_diff  w_neg_dy;
    t_span  w_adx;
    t_span  w_ady;
    t_diff  w_da;
    t_diff  w_db;
    logic   w_steep;
    logic   w_swap;
    t_coord w_a0;
    t_coord w_b0;
    t_coord w_a1;
    t_coord w_b1;

    always_comb begin
        w_dx     = t_diff'(i_end_x) - t_diff'(i_start_x);
        w_dy     = t_diff'(i_end_y) - t_diff'(i_start_y);
        w_neg_dx = -w_dx;
        w_neg_dy = -w_dy;
        w_adx    = w_dx[COORD_BITS] ? w_neg_dx[COORD_BITS-1:0] : w_dx[COORD_BITS-1:0];
        w_ady    = w_dy[COORD_BITS] ? w_neg_dy[COORD_BITS-1:0] : w_dy[COORD_BITS-1:0];
        w_steep  = w_ady > w_adx;

        w_da = w_steep ? w_dy : w_dx;
        w_db = w_steep ? w_dx : w_dy;
        w_a0 = w_steep ? i_start_y : i_start_x;
        w_b0 = w_steep ? i_start_x : i_start_y;
        w_a1 = w_steep ? i_end_y : i_end_x;
        w_b1 = w_steep ? i_end_x : i_end_y;
        w_swap = w_da[COORD_BITS];

        o_entry.cmd         = i_cmd;
        o_entry.steep       = w_steep;
        o_entry.major_start = w_swap ? w_a1 : w_a0;
        o_entry.minor_start = w_swap ? w_b1 : w_b0;
        o_entry.major_end   = w_swap ? w_a0 : w_a1;
        o_entry.major_span  = w_steep ? w_ady : w_adx;
        o_entry.minor_span  = w_steep ? w_adx : w_ady;
        // swapped endpoints reverse the minor direction
        o_entry.minor_dir   = w_swap ? !w_db[COORD_BITS]
                                     : (w_db[COORD_BITS] || (w_db == '0));
        o_entry.color       = i_color;
    end

endmodule

// ===== hw/rtl/lr_queue.sv =====
// Two-entry queue between the classifier and the pixel stepper.
// Depends on lr_pkg.
`timescale 1ns / 1ps

module lr_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  lr_pkg::t_lr_entry i_entry,
    input  logic              i_pop,
    output lr_pkg::t_lr_qout  o_qout,
    output lr_pkg::t_lr_qstat o_stat
);
    import lr_pkg::*;

    t_lr_entry  r_mem [2];
    logic       r_wptr;
    logic       r_rptr;
    logic [1:0] r_count;
    logic [1:0] n_count;
    logic       w_push;
    logic       w_pop;

    always_comb begin
        o_stat.full  = (r_count == 2'd2);
        o_stat.empty = (r_count == 2'd0);
        w_push       = i_push && !o_stat.full;
        w_pop        = i_pop && !o_stat.empty;
        n_count      = r_count + {1'b0, w_push} - {1'b0, w_pop};
        o_qout.valid = !o_stat.empty;
        o_qout.entry = r_mem[r_rptr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            r_count <= n_count;
            if (w_push) begin
                r_wptr <= !r_wptr;
            end
            if (w_pop) begin
                r_rptr <= !r_rptr;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wptr] <= i_entry;
        end
    end

endmodule

// ===== hw/rtl/lr_back.sv =====
// Back end: Bresenham stepper with line state and a registered pixel output.
// Depends on lr_pkg.
`timescale 1ns / 1ps

module lr_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  lr_pkg::t_lr_qout i_qout,
    input  logic             i_out_ready,
    output logic             o_out_valid,
    output lr_pkg::t_coord   o_pixel_x,
    output lr_pkg::t_coord   o_pixel_y,
    output lr_pkg::t_color   o_pixel_color,
    output logic             o_last_pixel,
    output lr_pkg::t_lr_bstat o_stat
);
    import lr_pkg::*;

    logic   r_active;
    logic   r_steep;
    logic   r_minor_dir;
    t_coord r_major_pos;
    t_coord r_minor_pos;
    t_coord r_major_end;
    t_span  r_major_span;
    t_span  r_minor_span;
    t_err   r_err;
    t_color r_color;
    logic   r_out_valid;
    t_coord r_px;
    t_coord r_py;
    t_color r_pc;
    logic   r_last;

    logic   n_active;
    logic   n_steep;
    logic   n_minor_dir;
    t_coord n_major_pos;
    t_coord n_minor_pos;
    t_coord n_major_end;
    t_span  n_major_span;
    t_span  n_minor_span;
    t_err   n_err;
    t_color n_color;
    logic   n_out_valid;

    logic   w_pop;
    logic   w_emit;
    logic   w_last;
    t_err   w_err_sub;
    t_lr_entry w_e;

    always_comb begin
        w_e          = i_qout.entry;
        w_pop        = i_qout.valid && (!r_out_valid || i_out_ready);
        n_active     = r_active;
        n_steep      = r_steep;
        n_minor_dir  = r_minor_dir;
        n_major_pos  = r_major_pos;
        n_minor_pos  = r_minor_pos;
        n_major_end  = r_major_end;
        n_major_span = r_major_span;
        n_minor_span = r_minor_span;
        n_err        = r_err;
        n_color      = r_color;
        w_emit       = 1'b0;
        w_err_sub    = r_err - t_err'({1'b0, r_minor_span});

        if (w_pop) begin
            unique case (w_e.cmd)
                CMD_START: begin
                    w_emit       = 1'b1;
                    n_steep      = w_e.steep;
                    n_minor_dir  = w_e.minor_dir;
                    n_major_pos  = w_e.major_start;
                    n_minor_pos  = w_e.minor_start;
                    n_major_end  = w_e.major_end;
                    n_major_span = w_e.major_span;
                    n_minor_span = w_e.minor_span;
                    n_err        = t_err'({1'b0, w_e.major_span >> 1});
                    n_color      = w_e.color;
                end
                CMD_ADVANCE: begin
                    w_emit      = r_active;
                    n_major_pos = r_major_pos + t_coord'(1);
                    if (w_err_sub[COORD_BITS]) begin
                        n_minor_pos = r_minor_dir ? r_minor_pos - t_coord'(1)
                                                  : r_minor_pos + t_coord'(1);
                        n_err       = w_err_sub + t_err'({1'b0, r_major_span});
                    end else begin
                        n_err = w_err_sub;
                    end
                    if (!r_active) begin
                        n_major_pos = r_major_pos;
                        n_minor_pos = r_minor_pos;
                        n_err       = r_err;
                    end
                end
                default: begin
                    w_emit = 1'b0;
                end
            endcase
        end

        w_last = (n_major_pos >= n_major_end);
        if (w_emit) begin
            n_active = !w_last;
        end
        n_out_valid = w_emit ? 1'b1 : (i_out_ready ? 1'b0 : r_out_valid);

        o_stat.pop       = w_pop;
        o_stat.active    = r_active;
        o_stat.emit_last = w_emit && w_last;
        o_out_valid      = r_out_valid;
        o_pixel_x        = r_px;
        o_pixel_y        = r_py;
        o_pixel_color    = r_pc;
        o_last_pixel     = r_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active     <= 1'b0;
            r_steep      <= 1'b0;
            r_minor_dir  <= 1'b0;
            r_major_pos  <= '0;
            r_minor_pos  <= '0;
            r_major_end  <= '0;
            r_major_span <= '0;
            r_minor_span <= '0;
            r_err        <= '0;
            r_color      <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_active     <= n_active;
            r_steep      <= n_steep;
            r_minor_dir  <= n_minor_dir;
            r_major_pos  <= n_major_pos;
            r_minor_pos  <= n_minor_pos;
            r_major_end  <= n_major_end;
            r_major_span <= n_major_span;
            r_minor_span <= n_minor_span;
            r_err        <= n_err;
            r_color      <= n_color;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_px   <= n_steep ? n_minor_pos : n_major_pos;
            r_py   <= n_steep ? n_major_pos : n_minor_pos;
            r_pc   <= n_color;
            r_last <= w_last;
        end
    end

endmodule

// ===== hw/rtl/line_rasterizer_core.sv =====
// Bresenham line rasterizer, top level: classifier, command queue and stepper.
// Depends on lr_pkg, lr_front, lr_queue, lr_back and line_rasterizer_core_macros.svh.
`timescale 1ns / 1ps
`include "line_rasterizer_core_macros.svh"

// A start command (tuser = 0) loads two endpoints and a color and yields the
// first pixel; each advance command (tuser = 1) yields the next pixel, the
// last one flagged by tlast. An advance with no line in progress yields
// nothing. Commands are taken at one per cycle while the queue is not full,
// and pixels leave at one per cycle while the output is ready: each advance
// is one error-term update in the stepper. A command passes the two-entry
// queue and then the pixel register before it reaches the output. Pixels
// are not clipped.
module line_rasterizer_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    // start_x, start_y, end_x, end_y, color
    input  logic [lr_pkg::S_DATA_W-1:0] s_axis_tdata,
    // command
    input  logic                        s_axis_tuser,
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    // pixel_x, pixel_y, pixel_color
    output logic [lr_pkg::M_DATA_W-1:0] m_axis_tdata,
    output logic                        m_axis_tlast
);
    import lr_pkg::*;

    t_lr_entry w_entry;
    t_lr_qout  w_qout;
    t_lr_qstat w_qstat;
    t_lr_bstat w_bstat;
    t_coord    w_px;
    t_coord    w_py;
    t_color    w_pc;
    logic      w_start_pop;
    logic      w_idle_adv;

    lr_front u_front (
        .i_cmd     (t_cmd'(s_axis_tuser)),
        .i_start_x (t_coord'(s_axis_tdata[COORD_BITS-1:0])),
        .i_start_y (t_coord'(s_axis_tdata[2*COORD_BITS-1:COORD_BITS])),
        .i_end_x   (t_coord'(s_axis_tdata[3*COORD_BITS-1:2*COORD_BITS])),
        .i_end_y   (t_coord'(s_axis_tdata[4*COORD_BITS-1:3*COORD_BITS])),
        .i_color   (t_color'(s_axis_tdata[4*COORD_BITS+COLOR_BITS-1:4*COORD_BITS])),
        .o_entry   (w_entry)
    );

    lr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (s_axis_tvalid),
        .i_entry (w_entry),
        .i_pop   (w_bstat.pop),
        .o_qout  (w_qout),
        .o_stat  (w_qstat)
    );

    lr_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_qout        (w_qout),
        .i_out_ready   (m_axis_tready),
        .o_out_valid   (m_axis_tvalid),
        .o_pixel_x     (w_px),
        .o_pixel_y     (w_py),
        .o_pixel_color (w_pc),
        .o_last_pixel  (m_axis_tlast),
        .o_stat        (w_bstat)
    );

    assign s_axis_tready = !w_qstat.full;
    assign m_axis_tdata  = M_DATA_W'({w_pc, w_py, w_px});

    assign w_start_pop = w_bstat.pop && (w_qout.entry.cmd == CMD_START);
    assign w_idle_adv  = w_bstat.pop && (w_qout.entry.cmd == CMD_ADVANCE)
                         && !w_bstat.active && !m_axis_tvalid;

    `LR_ASSERT_NOW(a_queue_state, i_clk, i_rst_n, 1'b1, !(w_qstat.full && w_qstat.empty))
    `LR_ASSERT_NEXT(a_start_emits, i_clk, i_rst_n, w_start_pop, m_axis_tvalid)
    `LR_ASSERT_NEXT(a_last_idles, i_clk, i_rst_n, w_bstat.emit_last, !w_bstat.active)
    `LR_ASSERT_NEXT(a_idle_advance, i_clk, i_rst_n, w_idle_adv, !m_axis_tvalid)

endmodule
